[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hdl/gmfe_pkg.sv]
// Package with the payload types, frame constants and helper functions of the frame encoder.
package gmfe_pkg;

	localparam int unsigned FRAME_LEN = 18;
	localparam logic [7:0] DIR_BYTE = 8'h05;
	localparam logic [7:0] LEN_BYTE = 8'h0D;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] ADDR_RESET = 8'h40;
	localparam logic [7:0] CMD_RESET = 8'hB0;

	// Configuration register indexes.
	localparam logic [0:0] REG_MODULE_ADDRESS = 1'b0;
	localparam logic [0:0] REG_COMMAND_CODE = 1'b1;

	typedef struct packed {
		logic [15:0] target_position;
		logic [15:0] move_speed;
		logic [15:0] move_accel;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} out_item_t;

	// Converted command carried from the front end to the serializer.
	typedef struct packed {
		logic [31:0] pos_bits;
		logic [31:0] spd_bits;
		logic [31:0] acc_bits;
	} cmd_t;

	// Exact single-precision pattern of a 16-bit unsigned integer.
	function automatic logic [31:0] u16_to_f32(input logic [15:0] v);
		logic [3:0]  e;
		logic [7:0]  ex;
		logic [15:0] sh;
		e = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) begin
				e = 4'(i);
			end
		end
		sh = v << (4'd15 - e);
		ex = 8'd127 + {4'd0, e};
		if (v == 16'd0) begin
			return 32'd0;
		end
		return {1'b0, ex, sh[14:0], 8'd0};
	endfunction

	// One byte of the reflected CRC-16/ARC update.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[hdl/gmfe_front.sv]
// Front end: accepts commands, converts the three values to float bits into a small queue.
module gmfe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  gmfe_pkg::in_item_t in_item,
	output logic               cmd_valid,
	input  logic               cmd_take,
	output gmfe_pkg::cmd_t     cmd
);
	// Two-entry queue of converted commands.
	gmfe_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign full = (count_q == 2'd2);
	assign do_push = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign do_pop = cmd_take && cmd_valid;
	assign cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= '{
				pos_bits: gmfe_pkg::u16_to_f32(in_item.target_position),
				spd_bits: gmfe_pkg::u16_to_f32(in_item.move_speed),
				acc_bits: gmfe_pkg::u16_to_f32(in_item.move_accel)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

[hdl/gmfe_back.sv]
// Back end: serializes one command into eighteen bytes with a running CRC and an output register.
module gmfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_take,
	input  gmfe_pkg::cmd_t      cmd,
	input  logic [7:0]          module_address,
	input  logic [7:0]          command_code,
	output logic                empty,
	input  logic                pop,
	output gmfe_pkg::out_item_t out_item
);
	logic [4:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic        can_load;
	logic        advance;
	logic [7:0]  cur_byte;
	logic [15:0] crc_next;

	assign empty = !out_valid_q;
	assign can_load = !out_valid_q || pop;
	assign advance = can_load && cmd_valid;
	assign cmd_take = advance && (idx_q == 5'(gmfe_pkg::FRAME_LEN - 1));
	assign crc_next = gmfe_pkg::crc_byte(crc_q, cur_byte);

	always_comb begin
		unique case (idx_q)
			5'd0: cur_byte = gmfe_pkg::DIR_BYTE;
			5'd1: cur_byte = module_address;
			5'd2: cur_byte = gmfe_pkg::LEN_BYTE;
			5'd3: cur_byte = command_code;
			5'd4: cur_byte = cmd.pos_bits[7:0];
			5'd5: cur_byte = cmd.pos_bits[15:8];
			5'd6: cur_byte = cmd.pos_bits[23:16];
			5'd7: cur_byte = cmd.pos_bits[31:24];
			5'd8: cur_byte = cmd.spd_bits[7:0];
			5'd9: cur_byte = cmd.spd_bits[15:8];
			5'd10: cur_byte = cmd.spd_bits[23:16];
			5'd11: cur_byte = cmd.spd_bits[31:24];
			5'd12: cur_byte = cmd.acc_bits[7:0];
			5'd13: cur_byte = cmd.acc_bits[15:8];
			5'd14: cur_byte = cmd.acc_bits[23:16];
			5'd15: cur_byte = cmd.acc_bits[31:24];
			5'd16: cur_byte = crc_q[7:0];
			5'd17: cur_byte = crc_q[15:8];
			default: cur_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item.frame_byte <= cur_byte;
			out_item.frame_end <= (idx_q == 5'(gmfe_pkg::FRAME_LEN - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 5'd0;
			crc_q <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_load) begin
				out_valid_q <= cmd_valid;
			end
			if (advance) begin
				if (idx_q == 5'(gmfe_pkg::FRAME_LEN - 1)) begin
					idx_q <= 5'd0;
					crc_q <= 16'd0;
				end else begin
					idx_q <= idx_q + 5'd1;
					if (idx_q < 5'd16) begin
						crc_q <= crc_next;
					end
				end
			end
		end
	end
endmodule

[hdl/gripper_move_frame_encoder_top.sv]
// Top level of the move-command frame encoder.
// Each transfer in carries a position, a speed and an acceleration; the block turns each into its
// exact single-precision pattern and sends an 18-byte frame: 0x05, the module id, 0x0D, the
// command code, the three floats low byte first and a CRC-16/ARC (initial value zero) low byte
// first, with frame_end set on the last byte. One byte leaves per cycle while a command waits and
// the output is empty or popped; the float conversion happens on input into a two-entry
// command queue, so new commands are taken while a frame is still going out. The output register
// holds a byte until popped. Configuration writes take effect at once and belong to idle times.
module gripper_move_frame_encoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  gmfe_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output gmfe_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	// Configuration registers.
	logic [7:0]     module_address_q;
	logic [7:0]     command_code_q;
	// Front-to-back handshake and command payload.
	logic           cmd_valid;
	logic           cmd_take;
	gmfe_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_address_q <= gmfe_pkg::ADDR_RESET;
			command_code_q <= gmfe_pkg::CMD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gmfe_pkg::REG_MODULE_ADDRESS: module_address_q <= cfg_data;
				gmfe_pkg::REG_COMMAND_CODE: command_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gmfe_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	gmfe_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.module_address(module_address_q), .command_code(command_code_q),
		.empty(empty), .pop(pop), .out_item(out_item)
	);
endmodule

[hdl/gmfe_checker.sv]
// Port-level checker for the frame encoder, with its bind statement.
`include "assert_macros.svh"
module gmfe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input gmfe_pkg::out_item_t out_item
);
	`CHK_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_item), "result changed while stalled")
	`CHK_IMPLY(a_full_nopush, clk, arst_n, full, !empty || $past(push), "full with no output pending")
	`CHK_NEXT(a_reset_empty, clk, arst_n, $rose(arst_n), empty || $past(push, 2), "output appeared from nothing")
endmodule

bind gripper_move_frame_encoder_top gmfe_checker u_chk (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty), .pop(pop),
	.out_item(out_item)
);
